// File: rtl/core/skf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int W        = 48;
  localparam int OW       = 49;
  localparam int FRAC     = 24;
  localparam int ACC_W    = 52;
  localparam int HC_W     = 7;
  localparam int PC_W     = 7;
  localparam int DIV_STEPS = 72;

  typedef logic signed [OW-1:0] word_t;

  localparam word_t SMAX   = 49'sd140737488355327;
  localparam word_t SMIN   = -49'sd140737488355328;
  localparam word_t ONE    = 49'sd16777216;
  localparam word_t SVI    = 49'sd167772;
  localparam word_t UMAX48 = 49'sd281474976710655;

  localparam logic [HC_W-1:0] MAX_HITS = 7'd64;

  typedef enum logic [2:0] {
    CFG_REF_X       = 3'd0,
    CFG_REF_Y       = 3'd1,
    CFG_REF_SLOPE_X = 3'd2,
    CFG_REF_SLOPE_Y = 3'd3,
    CFG_SCATTER     = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_MOV = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_LD  = 4'd3,
    OP_LD2 = 4'd4,
    OP_FIN = 4'd5,
    OP_MUL = 4'd6,
    OP_DIV = 4'd7,
    OP_CHI = 4'd8,
    OP_END = 4'd9
  } op_t;

  // scratch slots live in the state memory; codes with bit 5 set are constants or inputs
  typedef enum logic [5:0] {
    R_X = 6'd0, R_Y = 6'd1, R_TX = 6'd2, R_TY = 6'd3,
    R_C00 = 6'd4, R_C10 = 6'd5, R_C11 = 6'd6, R_C20 = 6'd7, R_C21 = 6'd8,
    R_C22 = 6'd9, R_C30 = 6'd10, R_C31 = 6'd11, R_C32 = 6'd12, R_C33 = 6'd13,
    R_CZ = 6'd14, R_CHI = 6'd15, R_DZ = 6'd16, R_DZ2 = 6'd17,
    R_T0 = 6'd18, R_T1 = 6'd19, R_T2 = 6'd20,
    R_H0 = 6'd21, R_H1 = 6'd22, R_H2 = 6'd23, R_H3 = 6'd24,
    R_RES = 6'd25, R_RR = 6'd26,
    R_K0 = 6'd27, R_K1 = 6'd28, R_K2 = 6'd29, R_K3 = 6'd30, R_T3 = 6'd31,
    K_ZERO = 6'd32, K_ONE = 6'd33, K_SVI = 6'd34, K_HZ = 6'd35,
    K_CA = 6'd36, K_CB = 6'd37, K_CC = 6'd38, K_HW = 6'd39,
    K_RX = 6'd40, K_RY = 6'd41, K_RTX = 6'd42, K_RTY = 6'd43, K_NOISE = 6'd44
  } opnd_t;

  typedef struct packed {
    op_t   op;
    opnd_t a;
    opnd_t b;
    opnd_t d;
  } uop_t;

  localparam logic [PC_W-1:0] PC_INIT = 7'd0;
  localparam logic [PC_W-1:0] PC_MAIN = 7'd18;
  localparam logic [PC_W-1:0] PC_LAST = 7'd113;

  function automatic word_t sat_sum(input logic signed [ACC_W-1:0] v);
    word_t r;
    if (v > ACC_W'(SMAX)) r = SMAX;
    else if (v < ACC_W'(SMIN)) r = SMIN;
    else r = v[OW-1:0];
    return r;
  endfunction

  function automatic word_t signed_sat(input logic [72:0] q, input logic neg);
    word_t r;
    if (neg) begin
      if (q >= 73'h800000000000) r = SMIN;
      else r = -$signed({1'b0, q[W-1:0]});
    end else begin
      if (q > 73'h7FFFFFFFFFFF) r = SMAX;
      else r = $signed({1'b0, q[W-1:0]});
    end
    return r;
  endfunction

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // first hit of a track: load the reference line
      7'd0:   u = '{OP_MUL, K_HZ,  K_RTX,  R_T0};
      7'd1:   u = '{OP_ADD, K_RX,  R_T0,   R_X};
      7'd2:   u = '{OP_MUL, K_HZ,  K_RTY,  R_T0};
      7'd3:   u = '{OP_ADD, K_RY,  R_T0,   R_Y};
      7'd4:   u = '{OP_MOV, K_RTX, K_ZERO, R_TX};
      7'd5:   u = '{OP_MOV, K_RTY, K_ZERO, R_TY};
      7'd6:   u = '{OP_MOV, K_ONE, K_ZERO, R_C00};
      7'd7:   u = '{OP_MOV, K_ZERO, K_ZERO, R_C10};
      7'd8:   u = '{OP_MOV, K_ONE, K_ZERO, R_C11};
      7'd9:   u = '{OP_MOV, K_ZERO, K_ZERO, R_C20};
      7'd10:  u = '{OP_MOV, K_ZERO, K_ZERO, R_C21};
      7'd11:  u = '{OP_MOV, K_SVI, K_ZERO, R_C22};
      7'd12:  u = '{OP_MOV, K_ZERO, K_ZERO, R_C30};
      7'd13:  u = '{OP_MOV, K_ZERO, K_ZERO, R_C31};
      7'd14:  u = '{OP_MOV, K_ZERO, K_ZERO, R_C32};
      7'd15:  u = '{OP_MOV, K_SVI, K_ZERO, R_C33};
      7'd16:  u = '{OP_MOV, K_HZ,  K_ZERO, R_CZ};
      7'd17:  u = '{OP_MOV, K_ZERO, K_ZERO, R_CHI};
      // propagate
      7'd18:  u = '{OP_SUB, K_HZ,  R_CZ,   R_DZ};
      7'd19:  u = '{OP_MUL, R_DZ,  R_DZ,   R_DZ2};
      7'd20:  u = '{OP_MUL, R_DZ,  R_TX,   R_T0};
      7'd21:  u = '{OP_ADD, R_X,   R_T0,   R_X};
      7'd22:  u = '{OP_MUL, R_DZ,  R_TY,   R_T0};
      7'd23:  u = '{OP_ADD, R_Y,   R_T0,   R_Y};
      7'd24:  u = '{OP_MOV, K_HZ,  K_ZERO, R_CZ};
      7'd25:  u = '{OP_MUL, R_DZ2, R_C22,  R_T0};
      7'd26:  u = '{OP_MUL, R_DZ,  R_C20,  R_T1};
      7'd27:  u = '{OP_LD2, R_T0,  R_T1,   R_T3};
      7'd28:  u = '{OP_FIN, R_C00, K_ZERO, R_C00};
      7'd29:  u = '{OP_MUL, R_DZ2, R_C32,  R_T0};
      7'd30:  u = '{OP_ADD, R_C30, R_C21,  R_T1};
      7'd31:  u = '{OP_MUL, R_DZ,  R_T1,   R_T1};
      7'd32:  u = '{OP_LD,  R_T0,  R_T1,   R_T3};
      7'd33:  u = '{OP_FIN, R_C10, K_ZERO, R_C10};
      7'd34:  u = '{OP_MUL, R_DZ,  R_C22,  R_T0};
      7'd35:  u = '{OP_ADD, R_C20, R_T0,   R_C20};
      7'd36:  u = '{OP_MUL, R_DZ,  R_C32,  R_T0};
      7'd37:  u = '{OP_ADD, R_C30, R_T0,   R_C30};
      7'd38:  u = '{OP_MUL, R_DZ2, R_C33,  R_T0};
      7'd39:  u = '{OP_MUL, R_DZ,  R_C31,  R_T1};
      7'd40:  u = '{OP_LD2, R_T0,  R_T1,   R_T3};
      7'd41:  u = '{OP_FIN, R_C11, K_ZERO, R_C11};
      7'd42:  u = '{OP_MUL, R_DZ,  R_C32,  R_T0};
      7'd43:  u = '{OP_ADD, R_C21, R_T0,   R_C21};
      7'd44:  u = '{OP_MUL, R_DZ,  R_C33,  R_T0};
      7'd45:  u = '{OP_ADD, R_C31, R_T0,   R_C31};
      // residual
      7'd46:  u = '{OP_MUL, K_CA,  R_X,    R_T0};
      7'd47:  u = '{OP_MUL, K_CB,  R_Y,    R_T1};
      7'd48:  u = '{OP_LD,  R_T0,  R_T1,   R_T3};
      7'd49:  u = '{OP_FIN, K_CC,  K_ZERO, R_RES};
      // C * H^T
      7'd50:  u = '{OP_MUL, R_C00, K_CA,   R_T0};
      7'd51:  u = '{OP_MUL, R_C10, K_CB,   R_T1};
      7'd52:  u = '{OP_ADD, R_T0,  R_T1,   R_H0};
      7'd53:  u = '{OP_MUL, R_C10, K_CA,   R_T0};
      7'd54:  u = '{OP_MUL, R_C11, K_CB,   R_T1};
      7'd55:  u = '{OP_ADD, R_T0,  R_T1,   R_H1};
      7'd56:  u = '{OP_MUL, R_C20, K_CA,   R_T0};
      7'd57:  u = '{OP_MUL, R_C21, K_CB,   R_T1};
      7'd58:  u = '{OP_ADD, R_T0,  R_T1,   R_H2};
      7'd59:  u = '{OP_MUL, R_C30, K_CA,   R_T0};
      7'd60:  u = '{OP_MUL, R_C31, K_CB,   R_T1};
      7'd61:  u = '{OP_ADD, R_T0,  R_T1,   R_H3};
      // innovation variance and chi2
      7'd62:  u = '{OP_DIV, K_ONE, K_HW,   R_T0};
      7'd63:  u = '{OP_MUL, K_CA,  R_H0,   R_T1};
      7'd64:  u = '{OP_MUL, K_CB,  R_H1,   R_T2};
      7'd65:  u = '{OP_LD,  R_T1,  R_T2,   R_T3};
      7'd66:  u = '{OP_FIN, R_T0,  K_ZERO, R_RR};
      7'd67:  u = '{OP_MUL, R_RES, R_RES,  R_T0};
      7'd68:  u = '{OP_DIV, R_T0,  R_RR,   R_T0};
      7'd69:  u = '{OP_CHI, R_CHI, R_T0,   R_CHI};
      // gain and state update
      7'd70:  u = '{OP_DIV, R_H0,  R_RR,   R_K0};
      7'd71:  u = '{OP_MUL, R_K0,  R_RES,  R_T0};
      7'd72:  u = '{OP_SUB, R_X,   R_T0,   R_X};
      7'd73:  u = '{OP_DIV, R_H1,  R_RR,   R_K1};
      7'd74:  u = '{OP_MUL, R_K1,  R_RES,  R_T0};
      7'd75:  u = '{OP_SUB, R_Y,   R_T0,   R_Y};
      7'd76:  u = '{OP_DIV, R_H2,  R_RR,   R_K2};
      7'd77:  u = '{OP_MUL, R_K2,  R_RES,  R_T0};
      7'd78:  u = '{OP_SUB, R_TX,  R_T0,   R_TX};
      7'd79:  u = '{OP_DIV, R_H3,  R_RR,   R_K3};
      7'd80:  u = '{OP_MUL, R_K3,  R_RES,  R_T0};
      7'd81:  u = '{OP_SUB, R_TY,  R_T0,   R_TY};
      // covariance update, lower triangle
      7'd82:  u = '{OP_MUL, R_K0,  R_H0,   R_T0};
      7'd83:  u = '{OP_SUB, R_C00, R_T0,   R_C00};
      7'd84:  u = '{OP_MUL, R_K1,  R_H0,   R_T0};
      7'd85:  u = '{OP_SUB, R_C10, R_T0,   R_C10};
      7'd86:  u = '{OP_MUL, R_K1,  R_H1,   R_T0};
      7'd87:  u = '{OP_SUB, R_C11, R_T0,   R_C11};
      7'd88:  u = '{OP_MUL, R_K2,  R_H0,   R_T0};
      7'd89:  u = '{OP_SUB, R_C20, R_T0,   R_C20};
      7'd90:  u = '{OP_MUL, R_K2,  R_H1,   R_T0};
      7'd91:  u = '{OP_SUB, R_C21, R_T0,   R_C21};
      7'd92:  u = '{OP_MUL, R_K2,  R_H2,   R_T0};
      7'd93:  u = '{OP_SUB, R_C22, R_T0,   R_C22};
      7'd94:  u = '{OP_MUL, R_K3,  R_H0,   R_T0};
      7'd95:  u = '{OP_SUB, R_C30, R_T0,   R_C30};
      7'd96:  u = '{OP_MUL, R_K3,  R_H1,   R_T0};
      7'd97:  u = '{OP_SUB, R_C31, R_T0,   R_C31};
      7'd98:  u = '{OP_MUL, R_K3,  R_H2,   R_T0};
      7'd99:  u = '{OP_SUB, R_C32, R_T0,   R_C32};
      7'd100: u = '{OP_MUL, R_K3,  R_H3,   R_T0};
      7'd101: u = '{OP_SUB, R_C33, R_T0,   R_C33};
      // scattering noise on the slope block
      7'd102: u = '{OP_MUL, K_RTX, K_RTX,  R_T0};
      7'd103: u = '{OP_ADD, K_ONE, R_T0,   R_T0};
      7'd104: u = '{OP_MUL, K_NOISE, R_T0, R_T0};
      7'd105: u = '{OP_ADD, R_C22, R_T0,   R_C22};
      7'd106: u = '{OP_MUL, K_RTY, K_RTY,  R_T0};
      7'd107: u = '{OP_ADD, K_ONE, R_T0,   R_T0};
      7'd108: u = '{OP_MUL, K_NOISE, R_T0, R_T0};
      7'd109: u = '{OP_ADD, R_C33, R_T0,   R_C33};
      7'd110: u = '{OP_MUL, K_NOISE, K_RTX, R_T0};
      7'd111: u = '{OP_MUL, R_T0,  K_RTY,  R_T0};
      7'd112: u = '{OP_ADD, R_C32, R_T0,   R_C32};
      default: u = '{OP_END, K_ZERO, K_ZERO, R_T3};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/skf_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module skf_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire skf_pkg::word_t op_a,
  input  wire skf_pkg::word_t op_b,
  output logic               done,
  output skf_pkg::word_t     result
);
  import skf_pkg::*;

  logic [W-1:0]   ma_r, mb_r;
  logic           neg_r;
  logic [2:0]     cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [95:0]    acc_r;
  word_t          res_r;
  logic [47:0]    pp;
  logic [95:0]    pp_sh;
  logic [96:0]    rnd;

  // one 24x24 partial product per cycle
  always_comb begin
    pp    = '0;
    pp_sh = '0;
    case (cnt_r[1:0])
      2'd0: begin
        pp    = ma_r[23:0] * mb_r[23:0];
        pp_sh = {48'd0, pp};
      end
      2'd1: begin
        pp    = ma_r[23:0] * mb_r[47:24];
        pp_sh = {24'd0, pp, 24'd0};
      end
      2'd2: begin
        pp    = ma_r[47:24] * mb_r[23:0];
        pp_sh = {24'd0, pp, 24'd0};
      end
      default: begin
        pp    = ma_r[47:24] * mb_r[47:24];
        pp_sh = {pp, 48'd0};
      end
    endcase
    rnd = {1'b0, acc_r} + 97'h800000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ma_r   <= op_a[OW-1] ? W'(-op_a) : op_a[W-1:0];
        mb_r   <= op_b[OW-1] ? W'(-op_b) : op_b[W-1:0];
        neg_r  <= op_a[OW-1] ^ op_b[OW-1];
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          res_r  <= signed_sat(rnd[96:24], neg_r);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          acc_r <= acc_r + pp_sh;
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

// File: rtl/core/skf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module skf_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire skf_pkg::word_t num,
  input  wire skf_pkg::word_t den,
  output logic               done,
  output skf_pkg::word_t     result
);
  import skf_pkg::*;

  logic [W-1:0]    ud_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    q_r;
  logic [71:0]     dvd_r;
  logic            neg_r;
  logic            ovf_r;
  logic            busy_r;
  logic            rnd_r;
  logic            done_r;
  logic [6:0]      cnt_r;
  word_t           res_r;
  logic [W-1:0]    un;
  logic [W-1:0]    ud;
  logic [W:0]      trial;
  logic            ge;
  logic [W:0]      qq;

  always_comb begin
    un    = num[OW-1] ? W'(-num) : num[W-1:0];
    ud    = den[OW-1] ? W'(-den) : den[W-1:0];
    trial = {rem_r, dvd_r[71]};
    ge    = trial >= {1'b0, ud_r};
    qq    = {1'b0, q_r} + {{W{1'b0}}, (rem_r >= (ud_r - rem_r))};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r <= num[OW-1] ^ den[OW-1];
        ud_r  <= ud;
        dvd_r <= {un, 24'd0};
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
        cnt_r <= '0;
        if (ud == '0) begin
          // divide by zero saturates by the quotient sign (numerator sign xor divisor sign); zero over zero gives zero
          if (un == '0) res_r <= '0;
          else res_r <= (num[OW-1] ^ den[OW-1]) ? SMIN : SMAX;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? W'(trial - {1'b0, ud_r}) : trial[W-1:0];
        q_r   <= {q_r[W-2:0], ge};
        ovf_r <= ovf_r | q_r[W-1];
        dvd_r <= {dvd_r[70:0], 1'b0};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
        if (ovf_r) res_r <= neg_r ? SMIN : SMAX;
        else res_r <= signed_sat({24'd0, qq}, neg_r);
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

// File: rtl/core/straight_track_kalman_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | tdata (low bit up)                               | tuser | tlast
// in_      | in        | hit_z, coef_a, coef_b, coef_c, hit_weight        | -     | last_hit
// out_     | out       | state_z, state_x, state_y, state_tx, state_ty,   | -     | track_done
//          |           | var_x, var_y, var_tx, var_ty, fit_chi2, dof      |       |
// cfg_     | in        | write enable, index, 48-bit data                 | -     | -
//
// A hit runs 96 micro-steps, each with a memory read state and a dispatch state; 46 of
// them wait on the shared multiplier and 6 wait on the radix-2 divider, which skips the
// division when the divisor is zero.
// The first hit of a track adds 18 load steps.
// Synchronous active-low reset; the state memory needs no clearing, since the first hit
// writes every slot before it is read.
// in_tready is high only between hits; a result waits in the output register and holds
// the sequencer only if the previous result has not been taken.

module straight_track_kalman_filter_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [239:0] in_tdata,   // hit_z, coef_a, coef_b, coef_c, hit_weight
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [487:0]      out_tdata,  // state_z, state_x, state_y, state_tx, state_ty,
                                        // var_x, var_y, var_tx, var_ty, fit_chi2,
                                        // degrees_freedom, one zero pad bit
  output logic              out_tlast,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_wdata
);
  import skf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;

  logic [W-1:0] ref_x_r, ref_y_r, ref_tx_r, ref_ty_r, noise_r;
  logic [W-1:0] hz_r, ca_r, cb_r, cc_r, hw_r;
  logic         last_r;
  logic         first_r;
  logic [HC_W-1:0] hc_r;

  word_t               mem [32];
  word_t               rd_a_r, rd_b_r;
  uop_t                uop_r;
  uop_t                cur_uop;
  logic signed [ACC_W-1:0] acc_r;

  logic [W-1:0] live_x_r, live_y_r, live_tx_r, live_ty_r;
  word_t        live_c00_r, live_c11_r, live_c22_r, live_c33_r;
  logic [W-1:0] live_chi_r;

  logic         out_tvalid_r;
  logic [487:0] out_tdata_r;
  logic         out_tlast_r;

  word_t        opa, opb;
  word_t        alu_res;
  logic signed [ACC_W-1:0] ea, eb;
  logic [OW:0]  chi_sum;
  logic         wr_en;
  word_t        wr_data;
  opnd_t        wr_dst;
  logic         mul_start, div_start;
  logic         mul_done, div_done;
  word_t        mul_res, div_res;
  logic         in_acc;
  logic         out_load;
  logic [HC_W-1:0] dof;

  function automatic word_t pick(input opnd_t code, input word_t memv,
                                 input logic [W-1:0] hz, input logic [W-1:0] ca,
                                 input logic [W-1:0] cb, input logic [W-1:0] cc,
                                 input logic [W-1:0] hw, input logic [W-1:0] rx,
                                 input logic [W-1:0] ry, input logic [W-1:0] rtx,
                                 input logic [W-1:0] rty, input logic [W-1:0] nz);
    word_t v;
    case (code)
      K_ZERO:  v = '0;
      K_ONE:   v = ONE;
      K_SVI:   v = SVI;
      K_HZ:    v = $signed({hz[W-1], hz});
      K_CA:    v = $signed({ca[W-1], ca});
      K_CB:    v = $signed({cb[W-1], cb});
      K_CC:    v = $signed({cc[W-1], cc});
      K_HW:    v = $signed({1'b0, hw});
      K_RX:    v = $signed({rx[W-1], rx});
      K_RY:    v = $signed({ry[W-1], ry});
      K_RTX:   v = $signed({rtx[W-1], rtx});
      K_RTY:   v = $signed({rty[W-1], rty});
      K_NOISE: v = $signed({1'b0, nz});
      default: v = memv;
    endcase
    return v;
  endfunction

  function automatic logic [W-1:0] out_var(input word_t v);
    return v[OW-1] ? '0 : v[W-1:0];
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cur_uop   = ucode(pc_r);

  // operands and simple arithmetic
  always_comb begin
    opa = pick(uop_r.a, rd_a_r, hz_r, ca_r, cb_r, cc_r, hw_r,
               ref_x_r, ref_y_r, ref_tx_r, ref_ty_r, noise_r);
    opb = pick(uop_r.b, rd_b_r, hz_r, ca_r, cb_r, cc_r, hw_r,
               ref_x_r, ref_y_r, ref_tx_r, ref_ty_r, noise_r);
    ea  = {{(ACC_W-OW){opa[OW-1]}}, opa};
    eb  = {{(ACC_W-OW){opb[OW-1]}}, opb};
    chi_sum = {1'b0, opa} + {opb[OW-1], opb};
    case (uop_r.op)
      OP_MOV:  alu_res = opa;
      OP_ADD:  alu_res = sat_sum(ea + eb);
      OP_SUB:  alu_res = sat_sum(ea - eb);
      OP_FIN:  alu_res = sat_sum(acc_r + ea);
      OP_CHI: begin
        // drop a non-positive increment, clamp at the unsigned top
        if (opb[OW-1] || opb == '0) alu_res = opa;
        else if (chi_sum > {1'b0, UMAX48}) alu_res = UMAX48;
        else alu_res = chi_sum[OW-1:0];
      end
      default: alu_res = opa;
    endcase
  end

  always_comb begin
    mul_start = (state_r == S_EXEC) && (uop_r.op == OP_MUL);
    div_start = (state_r == S_EXEC) && (uop_r.op == OP_DIV);
    wr_dst    = uop_r.d;
    wr_en     = 1'b0;
    wr_data   = alu_res;
    if (state_r == S_EXEC) begin
      wr_en = (uop_r.op == OP_MOV) || (uop_r.op == OP_ADD) || (uop_r.op == OP_SUB) ||
              (uop_r.op == OP_FIN) || (uop_r.op == OP_CHI);
    end else if (state_r == S_WAIT) begin
      wr_en   = mul_done || div_done;
      wr_data = (uop_r.op == OP_MUL) ? mul_res : div_res;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_FETCH;
          pc_nxt    = first_r ? PC_INIT : PC_MAIN;
        end
      end
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC: begin
        if (uop_r.op == OP_END) begin
          state_nxt = S_OUT;
        end else if (uop_r.op == OP_MUL || uop_r.op == OP_DIV) begin
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_FETCH;
          pc_nxt    = pc_r + 7'd1;
        end
      end
      S_WAIT: begin
        if (mul_done || div_done) begin
          state_nxt = S_FETCH;
          pc_nxt    = pc_r + 7'd1;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);
  assign dof      = hc_r - 7'd4;

  // state memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_dst[4:0]] <= wr_data;
    if (state_r == S_FETCH) begin
      rd_a_r <= mem[cur_uop.a[4:0]];
      rd_b_r <= mem[cur_uop.b[4:0]];
      uop_r  <= cur_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && uop_r.op == OP_LD) acc_r <= ea + eb;
    if (state_r == S_EXEC && uop_r.op == OP_LD2) acc_r <= ea + (eb <<< 1);
    if (in_acc) begin
      hz_r   <= in_tdata[47:0];
      ca_r   <= in_tdata[95:48];
      cb_r   <= in_tdata[143:96];
      cc_r   <= in_tdata[191:144];
      hw_r   <= in_tdata[239:192];
      last_r <= in_tlast;
    end
    // mirror the reported slots so the result loads straight from registers
    if (wr_en) begin
      case (wr_dst)
        R_X:   live_x_r   <= wr_data[W-1:0];
        R_Y:   live_y_r   <= wr_data[W-1:0];
        R_TX:  live_tx_r  <= wr_data[W-1:0];
        R_TY:  live_ty_r  <= wr_data[W-1:0];
        R_C00: live_c00_r <= wr_data;
        R_C11: live_c11_r <= wr_data;
        R_C22: live_c22_r <= wr_data;
        R_C33: live_c33_r <= wr_data;
        R_CHI: live_chi_r <= wr_data[W-1:0];
        default: ;
      endcase
    end
    if (out_load) begin
      out_tdata_r <= {1'b0, dof, live_chi_r,
                      out_var(live_c33_r), out_var(live_c22_r),
                      out_var(live_c11_r), out_var(live_c00_r),
                      live_ty_r, live_tx_r, live_y_r, live_x_r, hz_r};
      out_tlast_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pc_r         <= '0;
      first_r      <= 1'b1;
      hc_r         <= '0;
      out_tvalid_r <= 1'b0;
      ref_x_r      <= '0;
      ref_y_r      <= '0;
      ref_tx_r     <= '0;
      ref_ty_r     <= '0;
      noise_r      <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_REF_X:       ref_x_r  <= cfg_wdata;
          CFG_REF_Y:       ref_y_r  <= cfg_wdata;
          CFG_REF_SLOPE_X: ref_tx_r <= cfg_wdata;
          CFG_REF_SLOPE_Y: ref_ty_r <= cfg_wdata;
          CFG_SCATTER:     noise_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc && first_r) hc_r <= '0;
      if (state_r == S_EXEC && uop_r.op == OP_END && hc_r < MAX_HITS) hc_r <= hc_r + 7'd1;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        first_r      <= last_r;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  skf_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (opa),
    .op_b   (opb),
    .done   (mul_done),
    .result (mul_res)
  );

  skf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (opa),
    .den    (opb),
    .done   (div_done),
    .result (div_res)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTHESIS
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n) pc_r <= PC_LAST)
    else $error("sequencer ran past the last step");
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_FETCH)
    else $error("accepted hit did not start the sequencer");
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("both arithmetic units finished together");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_OUT)
    else $error("result appeared outside the output step");
`endif

endmodule

`default_nettype wire

// File: tb/straight_track_kalman_filter_unit_tb.sv
`timescale 1ns / 1ps

module straight_track_kalman_filter_unit_tb;
  import skf_pkg::*;

  localparam longint Q_ONE     = 64'sd16777216;
  localparam longint Q_SLOPEV  = 64'sd167772;
  localparam longint Q_MAX     = 64'sd140737488355327;
  localparam longint Q_MIN     = -64'sd140737488355328;
  localparam longint CHI_MAX   = 64'sd281474976710655;
  localparam int     HIT_LIMIT = 64;
  localparam int     CYCLE_LIMIT = 4000000;
  localparam logic [2:0] UNUSED_INDEX = 3'd7;

  typedef struct {
    longint z, a, b, c, w;
    bit last;
  } hit_t;

  typedef struct {
    logic [47:0] z, x, y, tx, ty, vx, vy, vtx, vty, chi2;
    logic [6:0]  dof;
    logic        done;
  } fit_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [239:0] in_tdata;   // hit_z, coef_a, coef_b, coef_c, hit_weight
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [487:0] out_tdata;  // state_z, state_x, state_y, state_tx, state_ty, var_x, var_y,
                            // var_tx, var_ty, fit_chi2, degrees_freedom, pad
  logic         out_tlast;
  logic         cfg_wr_en;
  logic [2:0]   cfg_index;
  logic [47:0]  cfg_wdata;

  straight_track_kalman_filter_unit uut (.*);

  // filter state shadow
  longint ref_reg[5];
  longint trk[4];
  longint cov[10];
  longint cur_z, chi_acc;
  int     hits_seen;
  bit     new_track;

  fit_t   fit_expected[$];
  int     error_count;
  int     cycle_count;
  bit     quiet;
  int     out_hold;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic longint clamp(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint mag_to_q(logic [127:0] q, bit neg);
    if (neg) return (q >= 128'h800000000000) ? Q_MIN : -longint'(q);
    return (q > 128'h7FFFFFFFFFFF) ? Q_MAX : longint'(q);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = ((ma * mb) + 128'h800000) >> 24;
    return mag_to_q(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [127:0] un, ud, q, r;
    bit neg;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    if (ud == 0) return (un == 0) ? 0 : (neg ? Q_MIN : Q_MAX);
    if (un / ud >= 128'h1000000) return neg ? Q_MIN : Q_MAX;
    q = (un << 24) / ud;
    r = (un << 24) % ud;
    if (r >= ud - r) q = q + 1;
    return mag_to_q(q, neg);
  endfunction

  function automatic int ci(int i, int j);
    if (j > i) return j * (j + 1) / 2 + i;
    return i * (i + 1) / 2 + j;
  endfunction

  function automatic logic [47:0] as_var(longint v);
    return (v < 0) ? 48'd0 : v[47:0];
  endfunction

  function automatic longint sx(logic [47:0] v);
    return longint'($signed(v));
  endfunction

  task automatic filter_hit(input hit_t h, output fit_t f);
    longint rtx, rty, nz, dz, dz2, res, rr, term;
    longint cht[4], k[4];
    rtx = ref_reg[CFG_REF_SLOPE_X];
    rty = ref_reg[CFG_REF_SLOPE_Y];
    nz  = ref_reg[CFG_SCATTER];
    if (new_track) begin
      trk[0] = clamp(ref_reg[CFG_REF_X] + qmul(h.z, rtx));
      trk[1] = clamp(ref_reg[CFG_REF_Y] + qmul(h.z, rty));
      trk[2] = rtx;
      trk[3] = rty;
      foreach (cov[i]) cov[i] = 0;
      cov[ci(0, 0)] = Q_ONE;
      cov[ci(1, 1)] = Q_ONE;
      cov[ci(2, 2)] = Q_SLOPEV;
      cov[ci(3, 3)] = Q_SLOPEV;
      cur_z = h.z;
      chi_acc = 0;
      hits_seen = 0;
      new_track = 0;
    end
    dz  = clamp(h.z - cur_z);
    dz2 = qmul(dz, dz);
    trk[0] = clamp(trk[0] + qmul(dz, trk[2]));
    trk[1] = clamp(trk[1] + qmul(dz, trk[3]));
    cur_z = h.z;
    cov[ci(0, 0)] = clamp(cov[ci(0, 0)] + qmul(dz2, cov[ci(2, 2)]) + 2 * qmul(dz, cov[ci(2, 0)]));
    cov[ci(1, 0)] = clamp(cov[ci(1, 0)] + qmul(dz2, cov[ci(3, 2)])
                          + qmul(dz, clamp(cov[ci(3, 0)] + cov[ci(2, 1)])));
    cov[ci(2, 0)] = clamp(cov[ci(2, 0)] + qmul(dz, cov[ci(2, 2)]));
    cov[ci(3, 0)] = clamp(cov[ci(3, 0)] + qmul(dz, cov[ci(3, 2)]));
    cov[ci(1, 1)] = clamp(cov[ci(1, 1)] + qmul(dz2, cov[ci(3, 3)]) + 2 * qmul(dz, cov[ci(3, 1)]));
    cov[ci(2, 1)] = clamp(cov[ci(2, 1)] + qmul(dz, cov[ci(3, 2)]));
    cov[ci(3, 1)] = clamp(cov[ci(3, 1)] + qmul(dz, cov[ci(3, 3)]));

    res = clamp(qmul(h.a, trk[0]) + qmul(h.b, trk[1]) + h.c);
    for (int i = 0; i < 4; i++)
      cht[i] = clamp(qmul(cov[ci(i, 0)], h.a) + qmul(cov[ci(i, 1)], h.b));
    rr = clamp(qdiv(Q_ONE, h.w) + qmul(h.a, cht[0]) + qmul(h.b, cht[1]));
    term = qdiv(qmul(res, res), rr);
    // drop negative chi2 increments
    if (term > 0) chi_acc = (chi_acc + term > CHI_MAX) ? CHI_MAX : chi_acc + term;
    for (int i = 0; i < 4; i++) begin
      k[i] = qdiv(cht[i], rr);
      trk[i] = clamp(trk[i] - qmul(k[i], res));
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j <= i; j++)
        cov[ci(i, j)] = clamp(cov[ci(i, j)] - qmul(k[i], cht[j]));

    cov[ci(2, 2)] = clamp(cov[ci(2, 2)] + qmul(nz, clamp(Q_ONE + qmul(rtx, rtx))));
    cov[ci(3, 3)] = clamp(cov[ci(3, 3)] + qmul(nz, clamp(Q_ONE + qmul(rty, rty))));
    cov[ci(3, 2)] = clamp(cov[ci(3, 2)] + qmul(qmul(nz, rtx), rty));
    if (hits_seen < HIT_LIMIT) hits_seen++;

    f.z    = cur_z[47:0];
    f.x    = trk[0][47:0];
    f.y    = trk[1][47:0];
    f.tx   = trk[2][47:0];
    f.ty   = trk[3][47:0];
    f.vx   = as_var(cov[ci(0, 0)]);
    f.vy   = as_var(cov[ci(1, 1)]);
    f.vtx  = as_var(cov[ci(2, 2)]);
    f.vty  = as_var(cov[ci(3, 3)]);
    f.chi2 = chi_acc[47:0];
    f.dof  = 7'(hits_seen - 4);
    f.done = h.last;
    if (h.last) new_track = 1;
  endtask

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    fit_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (fit_expected.size() == 0) begin
        report("unexpected transaction", out_tdata[47:0], 48'd0);
      end else begin
        e = fit_expected.pop_front();
        if (out_tdata[47:0]    !== e.z)    report("state_z", out_tdata[47:0], e.z);
        if (out_tdata[95:48]   !== e.x)    report("state_x", out_tdata[95:48], e.x);
        if (out_tdata[143:96]  !== e.y)    report("state_y", out_tdata[143:96], e.y);
        if (out_tdata[191:144] !== e.tx)   report("state_tx", out_tdata[191:144], e.tx);
        if (out_tdata[239:192] !== e.ty)   report("state_ty", out_tdata[239:192], e.ty);
        if (out_tdata[287:240] !== e.vx)   report("var_x", out_tdata[287:240], e.vx);
        if (out_tdata[335:288] !== e.vy)   report("var_y", out_tdata[335:288], e.vy);
        if (out_tdata[383:336] !== e.vtx)  report("var_tx", out_tdata[383:336], e.vtx);
        if (out_tdata[431:384] !== e.vty)  report("var_ty", out_tdata[431:384], e.vty);
        if (out_tdata[479:432] !== e.chi2) report("fit_chi2", out_tdata[479:432], e.chi2);
        if (out_tdata[486:480] !== e.dof)
          report("degrees_freedom", 48'(out_tdata[486:480]), 48'(e.dof));
        if (out_tlast !== e.done) report("track_done", 48'(out_tlast), 48'(e.done));
      end
    end
  end

  // result-side backpressure in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_hold <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold in_tvalid high after a transaction; the next call may lower it, a drain lowers it
  task automatic send_hit(input hit_t h);
    fit_t f;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {h.w[47:0], h.c[47:0], h.b[47:0], h.a[47:0], h.z[47:0]};
    in_tlast  <= h.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filter_hit(h, f);
    fit_expected.insert(fit_expected.size(), f);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fit_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[47:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx <= CFG_SCATTER)
      ref_reg[idx] = (idx == CFG_SCATTER) ? longint'(val[47:0]) : sx(val[47:0]);
  endtask

  function automatic longint raw48();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    return sx(v);
  endfunction

  // uniform value in +/- span, span in 1/256 units
  function automatic longint qrand(int span);
    return (longint'($urandom_range(0, 2 * span)) - span) * 65536;
  endfunction

  function automatic hit_t mk(longint z, longint a, longint b, longint c, longint w, bit last);
    hit_t h;
    h.z = z; h.a = a; h.b = b; h.c = c; h.w = w; h.last = last;
    return h;
  endfunction

  task automatic set_refs(longint x, longint y, longint sx_, longint sy_, longint nz);
    write_reg(CFG_REF_X, x);
    write_reg(CFG_REF_Y, y);
    write_reg(CFG_REF_SLOPE_X, sx_);
    write_reg(CFG_REF_SLOPE_Y, sy_);
    write_reg(CFG_SCATTER, nz);
  endtask

  task automatic test_field_extremes();
    send_hit(mk(0, Q_ONE, 0, 0, Q_ONE, 0));
    send_hit(mk(Q_MAX, Q_MAX, Q_MIN, Q_MAX, 48'hFFFFFFFFFFFF, 0));
    send_hit(mk(Q_MIN, Q_MIN, Q_MAX, Q_MIN, 1, 0));
    send_hit(mk(Q_ONE, 0, 0, Q_ONE, 0, 1));          // zero weight
    send_hit(mk(-Q_ONE, 0, 0, 0, 48'hFFFFFFFFFFFF, 1)); // single-hit track
    drain();
  endtask

  task automatic test_config_extremes();
    set_refs(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 48'hFFFFFFFFFFFF);
    send_hit(mk(Q_ONE, Q_ONE, Q_ONE, 0, Q_ONE, 0));
    send_hit(mk(2 * Q_ONE, -Q_ONE, Q_ONE, Q_MAX, Q_ONE, 1));
    drain();
    set_refs(Q_MIN, Q_MAX, 0, 0, 0);
    write_reg(UNUSED_INDEX, raw48());  // must be ignored
    send_hit(mk(5 * Q_ONE, Q_ONE, 0, Q_ONE, 100 * Q_ONE, 1));
    drain();
  endtask

  task automatic test_track_shapes();
    set_refs(Q_ONE, -2 * Q_ONE, Q_ONE / 8, -Q_ONE / 4, Q_ONE / 100);
    // hits out of z order, then a negative innovation variance attempt
    send_hit(mk(10 * Q_ONE, Q_ONE, 0, -Q_ONE, 4 * Q_ONE, 0));
    send_hit(mk(6 * Q_ONE, 0, Q_ONE, Q_ONE, 4 * Q_ONE, 0));
    send_hit(mk(8 * Q_ONE, Q_ONE / 2, Q_ONE / 2, 0, 48'hFFFFFFFFFFFF, 0));
    drain();
    // register writes between hits of one track
    write_reg(CFG_REF_SLOPE_X, -Q_ONE);
    write_reg(CFG_SCATTER, Q_ONE);
    send_hit(mk(12 * Q_ONE, Q_ONE, Q_ONE, 0, Q_ONE, 0));
    send_hit(mk(14 * Q_ONE, -Q_ONE, Q_ONE, 3 * Q_ONE, Q_ONE, 1));
    drain();
  endtask

  task automatic test_hit_limit();
    for (int i = 0; i < 70; i++)
      send_hit(mk(i * Q_ONE, qrand(256), qrand(256), qrand(512), Q_ONE + qrand(64) * 4,
                  i == 69));
    drain();
  endtask

  task automatic test_random_tracks(input int n_items);
    int sent, len;
    longint z;
    bit junk;
    sent = 0;
    while (sent < n_items) begin
      // wait for every hit in flight before touching the registers
      if ($urandom_range(0, 4) == 0) begin
        drain();
        set_refs(qrand(2560), qrand(2560), qrand(128), qrand(128),
                 longint'($urandom_range(0, 2560)) * 65536 / 100);
      end
      if ($urandom_range(0, 19) == 0) begin
        drain();
        set_refs(raw48(), raw48(), raw48(), raw48(), longint'({$urandom, $urandom} & 48'hFFFFFFFFFFFF));
      end
      len = $urandom_range(1, 12);
      z = qrand(25600);
      for (int i = 0; i < len; i++) begin
        junk = ($urandom_range(0, 7) == 0);
        z = z + longint'($urandom_range(32, 1280)) * 65536;
        if (junk)
          send_hit(mk(raw48(), raw48(), raw48(), raw48(),
                      longint'({$urandom, $urandom} & 48'hFFFFFFFFFFFF), i == len - 1));
        else
          send_hit(mk(z, qrand(512), qrand(512), qrand(2560),
                      longint'($urandom_range(26, 25600)) * 65536, i == len - 1));
        sent++;
        if (sent >= n_items - 40) quiet = 1;
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_REF_X;
    cfg_wdata = '0;
    out_tready = 1'b1;
    out_hold = 0;
    quiet = 0;
    error_count = 0;
    cycle_count = 0;
    foreach (ref_reg[i]) ref_reg[i] = 0;
    foreach (trk[i]) trk[i] = 0;
    foreach (cov[i]) cov[i] = 0;
    cur_z = 0;
    chi_acc = 0;
    hits_seen = 0;
    new_track = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_config_extremes();
    test_track_shapes();
    test_hit_limit();
    test_random_tracks(510);

    repeat (50) @(posedge clk);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
